@@ sv/preemptive_priority_scheduler_core_assert.svh @@
// assertion macros shared by the scheduler checks
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_ASSERT_SVH

// property holds in the same cycle as its antecedent
`define PPSCH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// property holds in the cycle after its antecedent
`define PPSCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

@@ sv/ppsch_pkg.sv @@
`timescale 1ns / 1ps

package ppsch_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int SLOT_FIELD_W   = 4;
	localparam int TIME_W         = 16;
	localparam int BURST_W        = 16;
	localparam int PRIO_W         = 8;
	localparam int COUNT_W        = 5;

	// item opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic                    op;
		logic [SLOT_FIELD_W-1:0] job_slot;
		logic [TIME_W-1:0]       arrival_time;
		logic [BURST_W-1:0]      burst_length;
		logic [PRIO_W-1:0]       job_priority;
		logic [TIME_W-1:0]       now_time;
	} job_word_t;

	typedef struct packed {
		logic                    finished_valid;
		logic [SLOT_FIELD_W-1:0] finished_slot;
		logic                    suspend_valid;
		logic [SLOT_FIELD_W-1:0] suspend_slot;
		logic                    dispatch_valid;
		logic [SLOT_FIELD_W-1:0] dispatch_slot;
		logic                    dispatch_resume;
		logic                    all_done;
	} result_word_t;

	// one job slot as held in the slot memory
	typedef struct packed {
		logic [TIME_W-1:0]  arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} slot_entry_t;

	// operands of the shared compare unit
	typedef struct packed {
		slot_entry_t       entry;
		logic [TIME_W-1:0] now;
		logic [PRIO_W-1:0] ref_a;
		logic [PRIO_W-1:0] ref_b;
	} cmp_req_t;

	// flags returned by the shared compare unit
	typedef struct packed {
		logic               arrived;
		logic               has_burst;
		logic               less_a;
		logic               less_b;
		logic [BURST_W-1:0] burst_next;
		logic               burst_next_zero;
	} cmp_rsp_t;

endpackage

@@ sv/ppsch_stream_if.sv @@
`timescale 1ns / 1ps

interface ppsch_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/preemptive_priority_scheduler_core.sv @@
`timescale 1ns / 1ps

// Preemptive priority scheduler over a table of job slots.
// job_in (sink): one word per item. op = load writes a slot's arrival time,
//   burst and priority and clears its started mark; op = tick carries now_time
//   and advances the schedule by one tick.
// result_out (source): exactly one word per item. A load returns an all-zero
//   word; a tick reports finish, suspend, dispatch (start or resume) and
//   all_done.
// cfg_we / cfg_wdata: writes job_count, the number of slots scanned per tick.
// Sequence: a load goes from ST_IDLE to ST_FINISH; a tick passes ST_RUN_RD,
//   ST_RUN_WB, ST_SCAN (job_count slots, capped at SLOT_COUNT), ST_DECIDE
//   and ST_FINISH. result_out.valid rises once ST_FINISH finds the output free.
//   The slot memory has one read port, so the tick scan reads one slot per
//   cycle through a single shared compare unit.
// Throughput: one item at a time; job_in.ready is high only while the
//   sequencer is idle, so the next item is taken only after the previous item
//   has left ST_FINISH.
// The result goes to an output register; the next item is taken while it
//   waits, but the following result is held until the receiver takes the word.
// Reset: no job running, all started marks clear, job_count 0. Slot contents
//   are undefined until loaded.
module preemptive_priority_scheduler_core #(
	parameter int SLOT_COUNT = ppsch_pkg::SLOT_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ppsch_stream_if.sink                      job_in,
	ppsch_stream_if.source                    result_out,
	input  logic                              cfg_we,
	input  logic [ppsch_pkg::COUNT_W-1:0]     cfg_wdata
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int SF_W   = ppsch_pkg::SLOT_FIELD_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RUN_RD = 3'd1;
	localparam logic [2:0] ST_RUN_WB = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]                        state_q;
	logic [ppsch_pkg::COUNT_W-1:0]     job_count_q;
	logic [ppsch_pkg::TIME_W-1:0]      now_q;
	logic                              running_valid_q;
	logic [SLOT_W-1:0]                 running_slot_q;
	logic [ppsch_pkg::PRIO_W-1:0]      run_prio_q;
	logic [SLOT_COUNT-1:0]             started_q;
	logic                              fin_q;
	logic [SLOT_W-1:0]                 fin_slot_q;
	logic [CNT_W-1:0]                  idx_q;
	logic                              rd_vld_s1;
	logic [SLOT_W-1:0]                 rd_idx_s1;
	logic                              best_a_valid_q;
	logic [SLOT_W-1:0]                 best_a_slot_q;
	logic [ppsch_pkg::PRIO_W-1:0]      best_a_prio_q;
	logic                              best_b_valid_q;
	logic [SLOT_W-1:0]                 best_b_slot_q;
	logic [ppsch_pkg::PRIO_W-1:0]      best_b_prio_q;
	logic                              any_burst_q;
	ppsch_pkg::result_word_t           res_pend_q;
	ppsch_pkg::result_word_t           result_q;
	logic                              out_valid_q;

	logic                              in_acc;
	logic                              load_in_range;
	logic [CNT_W-1:0]                  scan_n;
	logic                              issue;
	logic                              out_free;

	logic                              mem_we;
	logic [SLOT_W-1:0]                 mem_waddr;
	ppsch_pkg::slot_entry_t            mem_wdata;
	logic [SLOT_W-1:0]                 mem_raddr;
	ppsch_pkg::slot_entry_t            mem_rdata;

	ppsch_pkg::cmp_req_t               cmp_req;
	ppsch_pkg::cmp_rsp_t               cmp_rsp;

	logic                              base_valid;
	logic [SLOT_W-1:0]                 base_slot;
	logic [ppsch_pkg::PRIO_W-1:0]      base_prio;
	logic                              new_wins;
	logic                              top_valid;
	logic [SLOT_W-1:0]                 top_slot;
	logic                              disp;
	ppsch_pkg::result_word_t           tick_res;

	// handshakes
	assign job_in.ready     = state_q == ST_IDLE;
	assign in_acc           = job_in.valid && job_in.ready;
	assign result_out.valid = out_valid_q;
	assign result_out.data  = result_q;
	assign out_free         = !out_valid_q || result_out.ready;

	assign load_in_range = int'(job_in.data.job_slot) < SLOT_COUNT;
	assign scan_n = (int'(job_count_q) > SLOT_COUNT) ? CNT_W'(SLOT_COUNT)
		: CNT_W'(job_count_q);
	assign issue = idx_q < scan_n;

	// slot memory port muxing
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = running_slot_q;
		mem_wdata = '{arrival: mem_rdata.arrival, burst: cmp_rsp.burst_next,
			prio: mem_rdata.prio};
		mem_raddr = idx_q[SLOT_W-1:0];
		if (state_q == ST_IDLE) begin
			mem_we    = in_acc && job_in.data.op == ppsch_pkg::OP_LOAD && load_in_range;
			mem_waddr = SLOT_W'(job_in.data.job_slot);
			mem_wdata = '{arrival: job_in.data.arrival_time,
				burst: job_in.data.burst_length, prio: job_in.data.job_priority};
		end else if (state_q == ST_RUN_RD) begin
			mem_raddr = running_slot_q;
		end else if (state_q == ST_RUN_WB) begin
			mem_we = running_valid_q;
		end
	end

	ppsch_slot_mem #(
		.DEPTH  (SLOT_COUNT),
		.ADDR_W (SLOT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// candidate that stands before the new jobs are weighed
	always_comb begin
		base_valid = 1'b0;
		base_slot  = best_a_slot_q;
		base_prio  = best_a_prio_q;
		if (running_valid_q) begin
			base_valid = 1'b1;
			base_slot  = running_slot_q;
			base_prio  = run_prio_q;
		end else if (best_a_valid_q) begin
			base_valid = 1'b1;
		end
	end

	// shared compare unit operands
	always_comb begin
		cmp_req.entry = mem_rdata;
		cmp_req.now   = now_q;
		cmp_req.ref_a = best_a_prio_q;
		cmp_req.ref_b = best_b_prio_q;
		if (state_q == ST_DECIDE) begin
			cmp_req.entry.prio = best_b_prio_q;
			cmp_req.ref_a      = base_prio;
		end
	end

	ppsch_cmp_unit u_cmp (
		.req (cmp_req),
		.rsp (cmp_rsp)
	);

	// final pick and tick result
	always_comb begin
		new_wins  = best_b_valid_q && (!base_valid || cmp_rsp.less_a);
		top_valid = base_valid || best_b_valid_q;
		top_slot  = new_wins ? best_b_slot_q : base_slot;
		disp      = top_valid && (!running_valid_q || top_slot != running_slot_q);
		tick_res  = '0;
		tick_res.finished_valid = fin_q;
		tick_res.finished_slot  = fin_q ? SF_W'(fin_slot_q) : '0;
		tick_res.suspend_valid  = disp && running_valid_q;
		tick_res.suspend_slot   = (disp && running_valid_q) ? SF_W'(running_slot_q) : '0;
		tick_res.dispatch_valid = disp;
		tick_res.dispatch_slot  = disp ? SF_W'(top_slot) : '0;
		tick_res.dispatch_resume = disp && started_q[top_slot];
		tick_res.all_done       = !running_valid_q && !any_burst_q;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_count_q <= '0;
		end else if (cfg_we) begin
			job_count_q <= cfg_wdata;
		end
	end

	// sequencer and schedule state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			running_valid_q <= 1'b0;
			running_slot_q  <= '0;
			started_q       <= '0;
			rd_vld_s1       <= 1'b0;
			idx_q           <= '0;
			best_a_valid_q  <= 1'b0;
			best_b_valid_q  <= 1'b0;
			any_burst_q     <= 1'b0;
			fin_q           <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (job_in.data.op == ppsch_pkg::OP_LOAD) begin
							if (load_in_range) begin
								started_q[SLOT_W'(job_in.data.job_slot)] <= 1'b0;
							end
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_RUN_RD;
						end
					end
				end
				ST_RUN_RD: begin
					state_q <= ST_RUN_WB;
				end
				ST_RUN_WB: begin
					fin_q          <= running_valid_q && cmp_rsp.burst_next_zero;
					idx_q          <= '0;
					rd_vld_s1      <= 1'b0;
					best_a_valid_q <= 1'b0;
					best_b_valid_q <= 1'b0;
					any_burst_q    <= 1'b0;
					if (running_valid_q && cmp_rsp.burst_next_zero) begin
						started_q[running_slot_q] <= 1'b0;
						running_valid_q           <= 1'b0;
					end
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rd_vld_s1) begin
						if (cmp_rsp.has_burst) begin
							any_burst_q <= 1'b1;
						end
						if (started_q[rd_idx_s1] && !running_valid_q
								&& (!best_a_valid_q || cmp_rsp.less_a)) begin
							best_a_valid_q <= 1'b1;
						end
						if (cmp_rsp.arrived && cmp_rsp.has_burst && !started_q[rd_idx_s1]
								&& (!best_b_valid_q || cmp_rsp.less_b)) begin
							best_b_valid_q <= 1'b1;
						end
					end
					if (!issue && !rd_vld_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (disp) begin
						started_q[top_slot] <= 1'b1;
						running_valid_q     <= 1'b1;
						running_slot_q      <= top_slot;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan payload: candidate slots, priorities and captured tick data
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q <= job_in.data.now_time;
		end
		if (state_q == ST_RUN_WB) begin
			run_prio_q <= mem_rdata.prio;
			fin_slot_q <= running_slot_q;
		end
		if (state_q == ST_SCAN) begin
			rd_idx_s1 <= idx_q[SLOT_W-1:0];
			if (rd_vld_s1) begin
				if (started_q[rd_idx_s1] && !running_valid_q
						&& (!best_a_valid_q || cmp_rsp.less_a)) begin
					best_a_slot_q <= rd_idx_s1;
					best_a_prio_q <= mem_rdata.prio;
				end
				if (cmp_rsp.arrived && cmp_rsp.has_burst && !started_q[rd_idx_s1]
						&& (!best_b_valid_q || cmp_rsp.less_b)) begin
					best_b_slot_q <= rd_idx_s1;
					best_b_prio_q <= mem_rdata.prio;
				end
			end
		end
		if (state_q == ST_IDLE && in_acc) begin
			res_pend_q <= '0;
		end else if (state_q == ST_DECIDE) begin
			res_pend_q <= tick_res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			result_q <= res_pend_q;
		end
	end

endmodule

@@ sv/ppsch_slot_mem.sv @@
`timescale 1ns / 1ps

module ppsch_slot_mem #(
	parameter int DEPTH  = ppsch_pkg::SLOT_COUNT_DEF,
	parameter int ADDR_W = 4
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [ADDR_W-1:0]      waddr,
	input  ppsch_pkg::slot_entry_t wdata,
	input  logic [ADDR_W-1:0]      raddr,
	output ppsch_pkg::slot_entry_t rdata
);

	ppsch_pkg::slot_entry_t mem_q [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// single registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/ppsch_cmp_unit.sv @@
`timescale 1ns / 1ps

module ppsch_cmp_unit (
	input  ppsch_pkg::cmp_req_t req,
	output ppsch_pkg::cmp_rsp_t rsp
);

	// arrival check, burst decrement and the two priority compares
	always_comb begin
		rsp.arrived         = req.entry.arrival <= req.now;
		rsp.has_burst       = req.entry.burst != '0;
		rsp.less_a          = req.entry.prio < req.ref_a;
		rsp.less_b          = req.entry.prio < req.ref_b;
		rsp.burst_next      = rsp.has_burst ? req.entry.burst - 1'b1 : '0;
		rsp.burst_next_zero = rsp.burst_next == '0;
	end

endmodule

@@ sv/ppsch_checker.sv @@
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_core_assert.svh"

module ppsch_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input ppsch_pkg::result_word_t out_data
);

	// a stalled result word holds
	`PPSCH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// one item at a time: after acceptance the input side closes
	`PPSCH_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)

	// a preemption always comes with a dispatch and never with a finish
	`PPSCH_ASSERT_NOW(a_suspend_disp, clk, arst_n, out_valid && out_data.suspend_valid, out_data.dispatch_valid && !out_data.finished_valid)

	// nothing can be dispatched once all work is done
	`PPSCH_ASSERT_NOW(a_done_idle, clk, arst_n, out_valid && out_data.all_done, !out_data.dispatch_valid && !out_data.suspend_valid)

endmodule

bind preemptive_priority_scheduler_core ppsch_checker u_ppsch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (job_in.valid),
	.in_ready  (job_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_data  (result_out.data)
);
